>>> rtl/lpps_pkg.sv
// lpps_pkg: shared types, constants and phase table for the led pattern phase sequencer
`default_nettype none
package lpps_pkg;

  localparam int unsigned TimeBitsDefault = 32;
  localparam int unsigned NowBits         = 32;
  localparam int unsigned DurBits         = 10;
  localparam int unsigned RomDepth        = 12;
  localparam int unsigned RomIdxBits      = 4;
  localparam int unsigned PosBits         = 4;
  localparam int unsigned PhaseBits       = 3;
  localparam int unsigned InDataBits      = 40;
  localparam int unsigned OutDataBits     = 24;

  typedef enum logic [1:0] {
    EFF_STATIC = 2'd0,
    EFF_FLASH  = 2'd1,
    EFF_PULSE  = 2'd2
  } effect_e;

  typedef enum logic [1:0] {
    PAT_LOCKED  = 2'd0,
    PAT_GRANTED = 2'd1,
    PAT_DENIED  = 2'd2,
    PAT_LOCKOUT = 2'd3
  } pattern_e;

  typedef enum logic {
    KIND_SELECT = 1'b0,
    KIND_UPDATE = 1'b1
  } kind_e;

  typedef struct packed {
    logic               led_on;
    logic [1:0]         effect;
    logic [7:0]         interval_ms;
    logic [3:0]         repeats;
    logic [DurBits-1:0] dur;
  } phase_entry_t;

  typedef struct packed {
    logic [PhaseBits-1:0] phase_number;
    logic [3:0]           repeats;
    logic [7:0]           interval_ms;
    logic [1:0]           effect;
    logic                 led_on;
  } led_cmd_t;

  function automatic phase_entry_t phase_rom(input logic [RomIdxBits-1:0] idx);
    phase_entry_t e;
    e = '{1'b0, EFF_PULSE, 8'd100, 4'd1, 10'd220};
    unique case (idx)
      4'd0:  e = '{1'b0, EFF_STATIC, 8'd0,   4'd0, 10'd0};
      4'd1:  e = '{1'b0, EFF_FLASH,  8'd55,  4'd7, 10'd770};
      4'd2:  e = '{1'b0, EFF_PULSE,  8'd100, 4'd1, 10'd220};
      4'd3:  e = '{1'b0, EFF_PULSE,  8'd100, 4'd1, 10'd220};
      4'd4:  e = '{1'b0, EFF_PULSE,  8'd100, 4'd1, 10'd220};
      4'd5:  e = '{1'b0, EFF_PULSE,  8'd100, 4'd1, 10'd210};
      4'd6:  e = '{1'b0, EFF_PULSE,  8'd100, 4'd1, 10'd200};
      4'd7:  e = '{1'b0, EFF_PULSE,  8'd100, 4'd1, 10'd190};
      4'd8:  e = '{1'b0, EFF_PULSE,  8'd100, 4'd1, 10'd190};
      4'd9:  e = '{1'b0, EFF_PULSE,  8'd100, 4'd1, 10'd170};
      4'd10: e = '{1'b0, EFF_PULSE,  8'd100, 4'd1, 10'd160};
      4'd11: e = '{1'b1, EFF_STATIC, 8'd100, 4'd1, 10'd0};
      default: e = '{1'b0, EFF_STATIC, 8'd0, 4'd0, 10'd0};
    endcase
    return e;
  endfunction

  function automatic logic [RomIdxBits-1:0] pattern_base(input pattern_e pat);
    logic [RomIdxBits-1:0] b;
    unique case (pat)
      PAT_LOCKED:  b = 4'd0;
      PAT_GRANTED: b = 4'd1;
      PAT_DENIED:  b = 4'd2;
      PAT_LOCKOUT: b = 4'd4;
      default:     b = 4'd0;
    endcase
    return b;
  endfunction

  function automatic logic [PosBits-1:0] pattern_len(input pattern_e pat);
    logic [PosBits-1:0] l;
    unique case (pat)
      PAT_LOCKED:  l = 4'd1;
      PAT_GRANTED: l = 4'd1;
      PAT_DENIED:  l = 4'd2;
      PAT_LOCKOUT: l = 4'd8;
      default:     l = 4'd1;
    endcase
    return l;
  endfunction

endpackage
`default_nettype wire

>>> rtl/lpps_step.sv
// lpps_step: next phase state and led command for one word
`default_nettype none
module lpps_step import lpps_pkg::*; #(
  parameter int unsigned TimeBits = TimeBitsDefault
) (
  input  wire logic                 kind_i,
  input  wire logic [1:0]           indication_i,
  input  wire logic [NowBits-1:0]   now_ms_i,
  input  wire pattern_e             pat_i,
  input  wire logic [PosBits-1:0]   pos_i,
  input  wire logic [TimeBits-1:0]  start_i,
  output pattern_e                  pat_o,
  output logic      [PosBits-1:0]   pos_o,
  output logic      [TimeBits-1:0]  start_o,
  output logic                      emit_o,
  output led_cmd_t                  cmd_o
);

  logic [63:0]           now_wide;
  logic [TimeBits-1:0]   now_t;
  logic [TimeBits-1:0]   elapsed;
  logic [TimeBits-1:0]   dur_t;
  logic [PosBits-1:0]    len;
  logic [PosBits-1:0]    pos_inc;
  logic [RomIdxBits-1:0] cur_idx;
  logic [RomIdxBits-1:0] emit_idx;
  logic [PhaseBits-1:0]  emit_phase;
  phase_entry_t          cur;
  phase_entry_t          nxt;
  logic                  pending;
  logic                  due;

  assign now_wide = {{(64-NowBits){1'b0}}, now_ms_i};
  assign now_t    = now_wide[TimeBits-1:0];

  assign len      = pattern_len(pat_i);
  assign pending  = pos_i < len;
  assign cur_idx  = pattern_base(pat_i) + {1'b0, pos_i[PhaseBits-1:0]};
  assign cur      = phase_rom(cur_idx);
  assign dur_t    = {{(TimeBits-DurBits){1'b0}}, cur.dur};
  assign elapsed  = now_t - start_i;
  assign due      = pending && ((cur.dur == '0) || (elapsed >= dur_t));
  assign pos_inc  = pos_i + 4'd1;

  always_comb begin
    pat_o      = pat_i;
    pos_o      = pos_i;
    start_o    = start_i;
    emit_o     = 1'b0;
    emit_idx   = pattern_base(pat_i) + {1'b0, pos_inc[PhaseBits-1:0]};
    emit_phase = pos_inc[PhaseBits-1:0];
    if (kind_i == KIND_SELECT) begin
      pat_o      = pattern_e'(indication_i);
      pos_o      = '0;
      start_o    = now_t;
      emit_o     = 1'b1;
      emit_idx   = pattern_base(pattern_e'(indication_i));
      emit_phase = '0;
    end else if (due) begin
      pos_o   = pos_inc;
      start_o = start_i + dur_t;
      emit_o  = pos_inc < len;
    end
  end

  assign nxt = phase_rom(emit_idx);

  always_comb begin
    cmd_o.led_on       = nxt.led_on;
    cmd_o.effect       = nxt.effect;
    cmd_o.interval_ms  = nxt.interval_ms;
    cmd_o.repeats      = nxt.repeats;
    cmd_o.phase_number = emit_phase;
  end

endmodule
`default_nettype wire

>>> rtl/led_pattern_phase_sequencer.sv
// led_pattern_phase_sequencer: top level, phase state and output register
//
// channel  dir  tdata                                   tuser
// s_axis   in   indication[1:0] now_ms[33:2] pad to 40  kind
// m_axis   out  led_on[0] effect[2:1] interval_ms[10:3]  -
//               repeats[14:11] phase_number[17:15] pad to 24
//
// one word per cycle while s_axis is not stalled; a word's command appears on m_axis the cycle after acceptance
// phase rom read, wrap-safe elapsed subtract and compare sit between state and output register
// s_axis stalls only while a command waits and m_axis_tready is low
// after reset the locked pattern sits at phase 0 with start time 0, nothing pending on m_axis
`default_nettype none
module led_pattern_phase_sequencer import lpps_pkg::*; #(
  parameter int unsigned TimeBits = TimeBitsDefault
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [InDataBits-1:0]  s_axis_tdata,   // indication, now_ms, zero pad
  input  wire logic                   s_axis_tuser,   // kind
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [OutDataBits-1:0] m_axis_tdata    // led_on, effect, interval_ms,
                                                      // repeats, phase_number, zero pad
);

  pattern_e              pat_q, pat_d;
  logic [PosBits-1:0]    pos_q, pos_d;
  logic [TimeBits-1:0]   start_q, start_d;
  logic                  out_valid_q;
  led_cmd_t              cmd_q, cmd_d;
  logic                  emit;
  logic                  accept;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  lpps_step #(
    .TimeBits(TimeBits)
  ) u_step (
    .kind_i      (s_axis_tuser),
    .indication_i(s_axis_tdata[1:0]),
    .now_ms_i    (s_axis_tdata[33:2]),
    .pat_i       (pat_q),
    .pos_i       (pos_q),
    .start_i     (start_q),
    .pat_o       (pat_d),
    .pos_o       (pos_d),
    .start_o     (start_d),
    .emit_o      (emit),
    .cmd_o       (cmd_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q       <= PAT_LOCKED;
      pos_q       <= '0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pat_q       <= pat_d;
        pos_q       <= pos_d;
        start_q     <= start_d;
        out_valid_q <= emit;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      cmd_q <= cmd_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, cmd_q.phase_number, cmd_q.repeats, cmd_q.interval_ms,
                          cmd_q.effect, cmd_q.led_on};

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// tb_top: self-checking stream testbench for the led pattern phase sequencer
module tb_top import lpps_pkg::*;;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 100;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomWords = 350;

  typedef struct packed {
    logic       led_on;
    effect_e    effect;
    logic [7:0] interval_ms;
    logic [3:0] repeats;
    logic [9:0] dur;
  } phase_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [InDataBits-1:0]  s_axis_tdata = '0;   // indication, now_ms, zero pad
  logic                   s_axis_tuser = 1'b0; // kind
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata;        // led_on, effect, interval_ms,
                                               // repeats, phase_number, zero pad

  pattern_e    cur_pattern = PAT_LOCKED;
  logic [3:0]  cur_pos = 4'd0;
  logic [31:0] cur_start = 32'd0;
  led_cmd_t    cmd_q[$];

  logic        steady = 1'b0;
  logic        hold_req = 1'b0;
  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned selects_sent = 0;
  int unsigned cmds_checked = 0;
  int unsigned cycle_cnt = 0;
  led_cmd_t    got_cmd;
  led_cmd_t    want_cmd;

  led_pattern_phase_sequencer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [3:0] first_row(input pattern_e pat);
    case (pat)
      PAT_GRANTED: return 4'd1;
      PAT_DENIED:  return 4'd2;
      PAT_LOCKOUT: return 4'd4;
      default:     return 4'd0;
    endcase
  endfunction

  function automatic logic [3:0] phase_total(input pattern_e pat);
    case (pat)
      PAT_DENIED:  return 4'd2;
      PAT_LOCKOUT: return 4'd8;
      default:     return 4'd1;
    endcase
  endfunction

  function automatic phase_row_t step_entry(input pattern_e pat, input logic [2:0] idx);
    logic [3:0] row;
    row = first_row(pat) + 4'(idx);
    case (row)
      4'd0:    return '{1'b0, EFF_STATIC, 8'd0,  4'd0, 10'd0};
      4'd1:    return '{1'b0, EFF_FLASH,  8'd55, 4'd7, 10'd770};
      4'd5:    return '{1'b0, EFF_PULSE, 8'd100, 4'd1, 10'd210};
      4'd6:    return '{1'b0, EFF_PULSE, 8'd100, 4'd1, 10'd200};
      4'd7:    return '{1'b0, EFF_PULSE, 8'd100, 4'd1, 10'd190};
      4'd8:    return '{1'b0, EFF_PULSE, 8'd100, 4'd1, 10'd190};
      4'd9:    return '{1'b0, EFF_PULSE, 8'd100, 4'd1, 10'd170};
      4'd10:   return '{1'b0, EFF_PULSE, 8'd100, 4'd1, 10'd160};
      4'd11:   return '{1'b1, EFF_STATIC, 8'd100, 4'd1, 10'd0};
      default: return '{1'b0, EFF_PULSE, 8'd100, 4'd1, 10'd220};
    endcase
  endfunction

  function automatic void push_phase_cmd(input pattern_e pat, input logic [2:0] idx);
    phase_row_t row;
    led_cmd_t   cmd;
    row = step_entry(pat, idx);
    cmd.led_on       = row.led_on;
    cmd.effect       = row.effect;
    cmd.interval_ms  = row.interval_ms;
    cmd.repeats      = row.repeats;
    cmd.phase_number = idx;
    cmd_q.push_back(cmd);
  endfunction

  function automatic void predict_led_cmd(input kind_e kind, input logic [1:0] ind,
                                          input logic [31:0] now);
    phase_row_t  row;
    logic [3:0]  len;
    logic [31:0] elapsed;
    if (kind == KIND_SELECT) begin
      cur_pattern = pattern_e'(ind);
      cur_pos     = 4'd0;
      cur_start   = now;
      push_phase_cmd(cur_pattern, 3'd0);
      return;
    end
    len = phase_total(cur_pattern);
    if (cur_pos >= len) return;
    row     = step_entry(cur_pattern, cur_pos[2:0]);
    elapsed = now - cur_start;
    if (row.dur != 10'd0 && elapsed < 32'(row.dur)) return;
    cur_start = cur_start + 32'(row.dur);
    cur_pos   = cur_pos + 4'd1;
    if (cur_pos >= len) return;
    push_phase_cmd(cur_pattern, cur_pos[2:0]);
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_cmd = m_axis_tdata[17:0];
      if (cmd_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want_cmd = cmd_q.pop_front();
        compare_field("led_on", 32'(want_cmd.led_on), 32'(got_cmd.led_on));
        compare_field("effect", 32'(want_cmd.effect), 32'(got_cmd.effect));
        compare_field("interval_ms", 32'(want_cmd.interval_ms), 32'(got_cmd.interval_ms));
        compare_field("repeats", 32'(want_cmd.repeats), 32'(got_cmd.repeats));
        compare_field("phase_number", 32'(want_cmd.phase_number),
                      32'(got_cmd.phase_number));
        compare_field("pad", 32'd0, 32'(m_axis_tdata[OutDataBits-1:18]));
        cmds_checked++;
      end
    end
  end

  initial begin
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req      = 1'b0;
        m_axis_tready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      m_axis_tready = steady || ($urandom_range(99) >= 8);
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("%0t: run stopped after %0d cycles", $time, CycleLimit);
    $display("Some tests failed");
    $finish;
  end

  task automatic send_word(input kind_e kind, input logic [1:0] ind, input logic [31:0] now);
    while (!steady && $urandom_range(99) < 8) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = kind;
    s_axis_tdata  = {6'd0, now, ind};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_led_cmd(kind, ind, now);
    words_sent++;
    if (kind == KIND_SELECT) selects_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (cmd_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_after_reset();
    send_word(KIND_UPDATE, 2'd3, 32'd0);
    send_word(KIND_UPDATE, 2'd0, 32'hFFFF_FFFF);
    wait_drained();
  endtask

  task automatic test_each_pattern();
    send_word(KIND_SELECT, PAT_LOCKED, 32'hFFFF_FFFF);
    send_word(KIND_SELECT, PAT_GRANTED, 32'd5000);
    send_word(KIND_UPDATE, 2'd1, 32'd5769);
    send_word(KIND_UPDATE, 2'd2, 32'd5770);
    send_word(KIND_SELECT, PAT_DENIED, 32'd8000);
    send_word(KIND_UPDATE, 2'd0, 32'd8220);
    send_word(KIND_UPDATE, 2'd3, 32'd8439);
    send_word(KIND_UPDATE, 2'd1, 32'd8440);
    wait_drained();
  endtask

  task automatic test_lockout_overdue();
    send_word(KIND_SELECT, PAT_LOCKOUT, 32'h8000_0000);
    // far past every duration: one phase per tick, then the end of the pattern
    repeat (9) send_word(KIND_UPDATE, 2'd2, 32'h8000_1388);
    wait_drained();
  endtask

  task automatic test_time_wrap();
    send_word(KIND_SELECT, PAT_DENIED, 32'hFFFF_FF80);
    send_word(KIND_UPDATE, 2'd0, 32'h0000_0057);
    send_word(KIND_UPDATE, 2'd0, 32'h0000_005C);
    wait_drained();
  endtask

  task automatic test_reselect();
    send_word(KIND_SELECT, PAT_LOCKOUT, 32'd1000);
    send_word(KIND_UPDATE, 2'd1, 32'd1220);
    send_word(KIND_SELECT, PAT_GRANTED, 32'd1300);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (24) send_word(KIND_SELECT, 2'($urandom_range(3)), $urandom);
    wait_drained();
  endtask

  task automatic test_random_sequences(input int unsigned target);
    int unsigned base_cnt;
    int unsigned pick;
    logic [31:0] t;
    logic [31:0] deadline;
    pattern_e    pat;
    phase_row_t  row;
    base_cnt = words_sent;
    steady   = 1'b1;
    while (words_sent - base_cnt < target) begin
      if (words_sent - base_cnt >= target / 4) steady = 1'b0;
      if ($urandom_range(99) < 85) begin
        pick = $urandom_range(99);
        pat  = pick < 50 ? PAT_LOCKOUT : pick < 75 ? PAT_DENIED :
               pick < 90 ? PAT_GRANTED : PAT_LOCKED;
        t = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(600) : $urandom;
        send_word(KIND_SELECT, pat, t);
        repeat ($urandom_range(2, 16)) begin
          row      = step_entry(cur_pattern, cur_pos[2:0]);
          deadline = cur_start + 32'(row.dur);
          pick     = $urandom_range(99);
          if (pick < 35) t = t + $urandom_range(120);
          else if (pick < 55) t = deadline;
          else if (pick < 70) t = deadline - 32'd1;
          else if (pick < 90) t = t + $urandom_range(300, 3000);
          else if (pick < 95) t = $urandom;
          if (pick >= 95) send_word(KIND_SELECT, 2'($urandom_range(3)), t);
          else send_word(KIND_UPDATE, 2'($urandom_range(3)), t);
        end
      end else begin
        send_word(kind_e'($urandom_range(1)), 2'($urandom_range(3)), $urandom);
      end
    end
    steady = 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_after_reset();
    test_each_pattern();
    test_lockout_overdue();
    test_time_wrap();
    test_reselect();
    test_backpressure();
    test_random_sequences(RandomWords);
    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    $display("%0d words sent (%0d pattern selects), %0d led commands compared",
             words_sent, selects_sent, cmds_checked);
    $display("covered every pattern, overdue and wrapped timing, reselects and a long stall");
    if (errors == 0 && cmd_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> led_pattern_phase_sequencer.f
rtl/lpps_pkg.sv
rtl/lpps_step.sv
rtl/led_pattern_phase_sequencer.sv
tb/tb_top.sv
